### rtl/core/sha1bs_pkg.sv
// ----------------------------------------------------------------------------
// sha1bs_pkg
// Shared types, codes and round constants for the byte-stream SHA-1 hasher.
// ----------------------------------------------------------------------------
package sha1bs_pkg;

  // input word kinds
  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_LAST   = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  // classified command from front to back
  typedef struct packed {
    logic       has_byte;
    logic       finish;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned s);
    rotl = (x << s) | (x >> (32 - s));
  endfunction

endpackage

### rtl/core/sha1bs_front.sv
// ----------------------------------------------------------------------------
// sha1bs_front
// Accepts input words, drops unused codes and queues commands for the back end.
// ----------------------------------------------------------------------------
module sha1bs_front #(
  parameter int unsigned DEPTH = sha1bs_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       kind,
  input  logic [7:0]       data_byte,
  output logic             cmd_valid,
  input  logic             cmd_take,
  output sha1bs_pkg::cmd_t cmd
);
  import sha1bs_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t            mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     count;
  logic            push, pop;
  cmd_t            incoming;

  assign in_stall  = (count == (AW+1)'(DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = mem[rd_ptr];
  assign pop       = cmd_valid && cmd_take;

  // classify: kind none is accepted and dropped
  always_comb begin
    incoming.has_byte = (kind == KIND_DATA) || (kind == KIND_LAST);
    incoming.finish   = (kind == KIND_LAST) || (kind == KIND_FINISH);
    incoming.data     = data_byte;
  end
  assign push = in_valid && !in_stall && (kind != KIND_NONE);

  // queue storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= incoming;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

### rtl/core/sha1bs_back.sv
// ----------------------------------------------------------------------------
// sha1bs_back
// Block buffer, padding sequencer, 80-round compression and digest output.
// ----------------------------------------------------------------------------
module sha1bs_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_take,
  input  sha1bs_pkg::cmd_t cmd,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      digest_word,
  output logic             last_word
);
  import sha1bs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LOAD, S_ROUND, S_ADD, S_OUT
  } state_t;

  state_t       state;
  logic [31:0]  blk [16];
  logic [5:0]   fill;
  logic [63:0]  bit_length;
  logic [63:0]  len_snap;
  logic [31:0]  h [5];
  logic [31:0]  w [16];
  logic [31:0]  a, b, c, d, e;
  logic [6:0]   round;
  logic         finishing;
  logic         pad_done;
  logic         len_here;
  logic [2:0]   out_idx;

  logic         wr_en;
  logic [7:0]   wr_byte;
  logic [31:0]  w_new, w_cur, f, k, t;

  assign cmd_take = (state == S_IDLE) && cmd_valid;

  // byte written into the buffer this cycle
  // the length goes into the block only when the pad left room for it
  always_comb begin
    wr_en   = 1'b0;
    wr_byte = 8'h00;
    if (state == S_IDLE && cmd_valid && cmd.has_byte) begin
      wr_en   = 1'b1;
      wr_byte = cmd.data;
    end else if (state == S_PAD) begin
      wr_en = 1'b1;
      if (!pad_done)      wr_byte = PAD_BYTE;
      else if (fill < 6'd56 || !len_here) wr_byte = 8'h00;
      else wr_byte = len_snap[6'd63 - {fill[2:0], 3'b000} -: 8];
    end
  end

  // round logic
  always_comb begin
    w_new = rotl(w[13] ^ w[8] ^ w[2] ^ w[0], 1);
    w_cur = (round < 7'd16) ? w[0] : w_new;
    if (round < 7'd20) begin
      f = (b & c) | (~b & d); k = K0;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d; k = K1;
    end else if (round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d); k = K2;
    end else begin
      f = b ^ c ^ d; k = K3;
    end
    t = rotl(a, 5) + f + e + k + w_cur;
  end

  // buffer write
  always_ff @(posedge clk) begin
    if (wr_en) blk[fill[5:2]][5'd31 - {fill[1:0], 3'b000} -: 8] <= wr_byte;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      bit_length <= '0;
      finishing  <= 1'b0;
      pad_done   <= 1'b0;
      len_here   <= 1'b0;
      round      <= '0;
      out_idx    <= '0;
      h[0] <= H0; h[1] <= H1; h[2] <= H2; h[3] <= H3; h[4] <= H4;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            finishing <= cmd.finish;
            pad_done  <= 1'b0;
            len_here  <= 1'b0;
            if (cmd.has_byte) begin
              bit_length <= bit_length + 64'd8;
              len_snap   <= bit_length + 64'd8;
              fill       <= fill + 1'b1;
              if (fill == 6'd63) state <= S_LOAD;
              else if (cmd.finish) state <= S_PAD;
            end else begin
              len_snap <= bit_length;
              state    <= S_PAD;
            end
          end
        end
        S_PAD: begin
          pad_done <= 1'b1;
          // a pad at offset 56 or later pushes the length into the next block
          if (!pad_done) len_here <= (fill < 6'd56);
          fill     <= fill + 1'b1;
          if (fill == 6'd63) state <= S_LOAD;
        end
        S_LOAD: begin
          for (int i = 0; i < 16; i++) w[i] <= blk[i];
          a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
          round <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_cur;
          e <= d; d <= c; c <= rotl(b, 30); b <= a; a <= t;
          round <= round + 1'b1;
          if (round == 7'd79) state <= S_ADD;
        end
        S_ADD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          out_idx <= '0;
          // a finish that has written its length ends the message
          if (finishing && pad_done && len_here) state <= S_OUT;
          else if (finishing) begin
            len_here <= 1'b1;
            state    <= S_PAD;
          end
          else state <= S_IDLE;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_idx <= out_idx + 1'b1;
            if (out_idx == 3'd4) begin
              h[0] <= H0; h[1] <= H1; h[2] <= H2; h[3] <= H3; h[4] <= H4;
              bit_length <= '0;
              finishing  <= 1'b0;
              state      <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid   = (state == S_OUT);
  assign digest_word = h[(out_idx > 3'd4) ? 3'd4 : out_idx];
  assign last_word   = (out_idx == 3'd4);
endmodule

### rtl/core/sha1_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher
// SHA-1 over a byte stream; a finish word pads and emits the 160-bit digest.
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// in       sink       in_valid/in_stall   kind, data_byte
// out      source     out_valid/out_stall digest_word, last_word
//
// a data byte is written into the block buffer while idle; a full block then runs
// load, 80 rounds at one per cycle, chaining add
// a finish pads one byte per cycle and runs one or two blocks, then 5 words
// a 4-entry command queue lets the input run ahead while a block compresses
// reset is synchronous and restores the initial chaining values
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher #(
  parameter int unsigned QUEUE_DEPTH = sha1bs_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic        last_word
);
  import sha1bs_pkg::*;

  logic cmd_valid, cmd_take;
  cmd_t cmd;

  sha1bs_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst, .in_valid, .in_stall, .kind, .data_byte,
    .cmd_valid, .cmd_take, .cmd
  );

  sha1bs_back u_back (
    .clk, .rst, .cmd_valid, .cmd_take, .cmd,
    .out_valid, .out_stall, .digest_word, .last_word
  );

  // commands are only taken from a non-empty queue
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> cmd_valid) else $error("command taken from empty queue");

  // digest words do not overlap command intake
  a_out_no_take: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !cmd_take) else $error("command taken during digest output");

  // after the last word is sent, output drops
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_word) |=> !out_valid)
    else $error("output continued after last word");
endmodule

### verif/sha1_digest_checker.sv
// ----------------------------------------------------------------------------
// sha1_digest_checker
// Watches the byte and digest channels of the SHA-1 hasher, computes the
// digest of each message on its own and compares every emitted word.
// ----------------------------------------------------------------------------
module sha1_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] digest_word,
  input  logic        last_word,
  output int          fail_count,
  output int          words_pending
);
  import sha1bs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_word_t;

  logic [31:0] chain [5];
  logic [7:0]  block_buf [64];
  int unsigned fill;
  logic [63:0] msg_bits;
  digest_word_t digest_q [$];

  assign words_pending = digest_q.size();

  function automatic logic [31:0] rot_left(logic [31:0] x, int unsigned s);
    return (x << s) | (x >> (32 - s));
  endfunction

  // restore the initial chaining words and empty the block
  function automatic void clear_message();
    chain[0] = H0; chain[1] = H1; chain[2] = H2; chain[3] = H3; chain[4] = H4;
    fill = 0;
    msg_bits = '0;
  endfunction

  // 80-round compression of the full block
  function automatic void compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rot_left(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d); k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d; k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K2;
      end else begin
        f = b ^ c ^ d; k = K3;
      end
      t = rot_left(a, 5) + f + e + k + w[r];
      e = d; d = c; c = rot_left(b, 30); b = a; a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endfunction

  function automatic void add_byte(logic [7:0] v);
    block_buf[fill] = v;
    fill++;
    if (fill == 64) begin
      compress();
      fill = 0;
    end
  endfunction

  // pad, append length, queue the five digest words
  function automatic void finish_message();
    logic [63:0] len;
    digest_word_t dw;
    len = msg_bits;
    add_byte(PAD_BYTE);
    while (fill != 56) add_byte(8'h00);
    for (int i = 0; i < 8; i++) add_byte(len[63-8*i -: 8]);
    for (int i = 0; i < 5; i++) begin
      dw.word = chain[i];
      dw.last = (i == 4);
      digest_q.push_back(dw);
    end
    clear_message();
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("error at %0t: %s got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    clear_message();
  end

  // accepted input words
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      case (kind_t'(kind))
        KIND_DATA: begin
          msg_bits += 64'd8;
          add_byte(data_byte);
        end
        KIND_LAST: begin
          msg_bits += 64'd8;
          add_byte(data_byte);
          finish_message();
        end
        KIND_FINISH: finish_message();
        default: ;
      endcase
    end
  end

  // accepted digest words
  always @(posedge clk) begin
    digest_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        report("unexpected digest word", digest_word, '0);
      end else begin
        want = digest_q.pop_front();
        if (digest_word !== want.word) report("digest_word", digest_word, want.word);
        if (last_word !== want.last)
          report("last_word", 32'(last_word), 32'(want.last));
      end
    end
  end

endmodule

### verif/tb_sha1_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// tb_sha1_byte_stream_hasher
// Sends byte streams of varied lengths and finish kinds into the hasher with
// random gaps and output stalls; the checker compares every digest word.
// ----------------------------------------------------------------------------
module tb_sha1_byte_stream_hasher;
  import sha1bs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = KIND_DATA;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic        last_word;
  int          fail_count;
  int          words_pending;
  int          cycles = 0;
  bit          no_idle = 1'b0;
  bit          hold_off = 1'b0;

  always #2 clk = ~clk;

  sha1_byte_stream_hasher u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .data_byte(data_byte), .out_valid(out_valid),
    .out_stall(out_stall), .digest_word(digest_word), .last_word(last_word)
  );

  sha1_digest_checker u_check (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .data_byte(data_byte), .out_valid(out_valid),
    .out_stall(out_stall), .digest_word(digest_word), .last_word(last_word),
    .fail_count(fail_count), .words_pending(words_pending)
  );

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sha1_byte_stream_hasher: mismatch");
      $finish;
    end
  end

  // receiver stalls, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_off) out_stall <= 1'b1;
    else if (no_idle) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 34);
  end

  // send one word, idling at random before it
  task automatic send_word(kind_t k, logic [7:0] b);
    if (!no_idle) begin
      while ($urandom_range(99) < 34) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    kind <= k;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_message(int n_bytes, bit with_last);
    for (int i = 0; i < n_bytes; i++) send_word(KIND_DATA, 8'($urandom));
    if (with_last) send_word(KIND_LAST, 8'($urandom));
    else send_word(KIND_FINISH, 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty message, byte extremes, unused kind, pad past offset 56
    send_word(KIND_FINISH, 8'hFF);
    send_word(KIND_NONE, 8'hA5);
    send_word(KIND_LAST, 8'h00);
    send_word(KIND_DATA, 8'hFF);
    send_word(KIND_NONE, 8'h5A);
    send_word(KIND_LAST, 8'hFF);
    send_message(59, 1'b1);
    drain();

    // long output hold-off: the command queue fills and stalls the input
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_message(2, 1'b1);
        send_message(0, 1'b0);
        send_message(3, 1'b1);
      end
    join
    drain();

    // random short messages, a stretch with no idling
    for (int m = 0; m < 9; m++) begin
      no_idle = (m >= 2 && m < 6);
      send_message(int'($urandom_range(6)), 1'($urandom_range(1)));
      if ($urandom_range(3) == 0) send_word(KIND_NONE, 8'($urandom));
    end
    no_idle = 1'b0;
    drain();

    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("sha1_byte_stream_hasher: match");
    else $display("sha1_byte_stream_hasher: mismatch");
    $finish;
  end

endmodule
